[sv/pxk_pkg.sv]
// Shared types, constants and helpers for the permutation XOR keystream core.
`default_nettype none

package pxk_pkg;

  // Array length and derived widths
  localparam int LENGTH   = 21;
  localparam int ADDR_W   = $clog2(LENGTH);
  localparam int CNT_W    = $clog2(LENGTH + 1);
  localparam int INDEX_W  = 5;
  localparam int BYTE_W   = 8;

  // Request codes
  typedef enum logic [1:0] {
    MODE_KEY    = 2'd0,
    MODE_FIXED  = 2'd1,
    MODE_EVOLVE = 2'd2,
    MODE_STEP   = 2'd3
  } pxk_mode_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XOR,
    ST_CONJ
  } pxk_state_e;

  // Input request
  typedef struct packed {
    pxk_mode_e            mode;
    logic [INDEX_W-1:0]   index;
    logic [BYTE_W-1:0]    value;
  } pxk_in_t;

  // Output request
  typedef struct packed {
    logic [BYTE_W-1:0]    key_byte;
    logic                 last;
  } pxk_out_t;

  // Map an out-of-range table entry to position zero
  function automatic logic [ADDR_W-1:0] pos_of(input logic [ADDR_W-1:0] v);
    return (int'(v) < LENGTH) ? v : '0;
  endfunction

endpackage

`default_nettype wire

[sv/permutation_xor_keystream_core.sv]
// Top level: keystream generator over a byte array and two permutations held in RAMs.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | input     | in_valid_i / in_ready_o | in_req_i  (mode, index, value)
//  out     | output    | out_valid_o/out_ready_i | out_req_o (key_byte, last)
//
// In-range load requests are written straight into the RAMs.
// A step request runs a three-stage
// read/XOR/write pass over the byte RAMs, then a four-stage conjugation pass
// (inverse, evolving, fixed lookups) that writes the spare evolving bank.
// Output back-pressure freezes the XOR pass; the conjugation pass never stalls.
// Reset clears only control state; RAM contents are undefined until loaded.
`default_nettype none

module permutation_xor_keystream_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire pxk_pkg::pxk_in_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output pxk_pkg::pxk_out_t     out_req_o
);

  import pxk_pkg::*;

  pxk_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0] vld_q, vld_d;
  logic [ADDR_W-1:0] idx1_q, idx2_q, idx3_q;
  logic [ADDR_W-1:0] p2_q;
  logic sel_q, sel_d;
  logic fwd_vld_q, fwd_vld_d;
  logic [ADDR_W-1:0] fwd_idx_q;
  logic [BYTE_W-1:0] fwd_data_q;
  logic out_valid_q, out_valid_d;
  pxk_out_t out_q;

  logic xor_act, conj_act;
  logic in_acc, step_acc, idx_ok, val_ok;
  logic ld_key, ld_fix, ld_evo;
  logic adv, go, issue, xor_done, conj_done;
  logic x_we, conj_we;
  logic [ADDR_W-1:0] ld_addr, ld_val;
  logic [BYTE_W-1:0] ba_rd, bb_rd, a_byte, x_byte;
  logic [ADDR_W-1:0] ev_rd, ev_raddr, f_rd, finv_rd;
  logic [ADDR_W-1:0] ev_rd_bank [2];
  logic ev_re, finv_re;

  // Load decode
  assign in_acc   = in_valid_i && in_ready_o;
  assign idx_ok   = int'(in_req_i.index) < LENGTH;
  assign val_ok   = int'(in_req_i.value) < LENGTH;
  assign step_acc = in_acc && (in_req_i.mode == MODE_STEP);
  assign ld_key   = in_acc && (in_req_i.mode == MODE_KEY) && idx_ok;
  assign ld_fix   = in_acc && (in_req_i.mode == MODE_FIXED) && idx_ok && val_ok;
  assign ld_evo   = in_acc && (in_req_i.mode == MODE_EVOLVE) && idx_ok && val_ok;
  assign ld_addr  = ADDR_W'(in_req_i.index);
  assign ld_val   = ADDR_W'(in_req_i.value);

  // Pipeline advance: the XOR pass waits on a full output register
  assign adv       = !out_valid_q || out_ready_i;
  assign go        = xor_act ? adv : 1'b1;
  assign issue     = (xor_act || conj_act) && go && (cnt_q < CNT_W'(LENGTH));
  assign xor_done  = xor_act && (cnt_q == CNT_W'(LENGTH)) && !vld_q[0] && !vld_q[1];
  assign conj_done = conj_act && (cnt_q == CNT_W'(LENGTH)) && (vld_q == 3'b000);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (step_acc) state_d = ST_XOR;
      ST_XOR:  if (xor_done) state_d = ST_CONJ;
      ST_CONJ: if (conj_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    xor_act    = 1'b0;
    conj_act   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_XOR:  xor_act    = 1'b1;
      ST_CONJ: conj_act   = 1'b1;
      default: in_ready_o = 1'b0;
    endcase
  end

  // Entry counter, stage valids, bank select
  always_comb begin
    cnt_d = cnt_q;
    if (step_acc || xor_done) begin
      cnt_d = '0;
    end else if (issue) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    vld_d = vld_q;
    if (go) begin
      vld_d = {vld_q[1] && conj_act, vld_q[0], issue};
    end
    sel_d = conj_done ? !sel_q : sel_q;
  end

  // XOR stage: forward the previous write when it hits the permuted index
  assign a_byte  = (fwd_vld_q && (fwd_idx_q == p2_q)) ? fwd_data_q : ba_rd;
  assign x_byte  = bb_rd ^ a_byte;
  assign x_we    = xor_act && go && vld_q[1];
  assign conj_we = conj_act && vld_q[2];

  always_comb begin
    fwd_vld_d = fwd_vld_q;
    if (step_acc) begin
      fwd_vld_d = 1'b0;
    end else if (x_we) begin
      fwd_vld_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (x_we) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      vld_q       <= '0;
      sel_q       <= 1'b0;
      fwd_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      vld_q       <= vld_d;
      sel_q       <= sel_d;
      fwd_vld_q   <= fwd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (go) begin
      idx1_q <= cnt_q[ADDR_W-1:0];
      idx2_q <= idx1_q;
      idx3_q <= idx2_q;
      p2_q   <= pos_of(ev_rd);
    end
    if (x_we) begin
      fwd_idx_q      <= idx2_q;
      fwd_data_q     <= x_byte;
      out_q.key_byte <= x_byte;
      out_q.last     <= (idx2_q == ADDR_W'(LENGTH - 1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // Byte store, two copies for the two reads of the XOR pass
  pxk_ram #(.WIDTH(BYTE_W), .DEPTH(LENGTH)) u_byte_a (
    .clk_i   (clk_i),
    .we_i    (ld_key || x_we),
    .waddr_i (x_we ? idx2_q : ld_addr),
    .wdata_i (x_we ? x_byte : in_req_i.value),
    .re_i    (x_we || (xor_act && go && vld_q[0])),
    .raddr_i (pos_of(ev_rd)),
    .rdata_o (ba_rd)
  );

  pxk_ram #(.WIDTH(BYTE_W), .DEPTH(LENGTH)) u_byte_b (
    .clk_i   (clk_i),
    .we_i    (ld_key || x_we),
    .waddr_i (x_we ? idx2_q : ld_addr),
    .wdata_i (x_we ? x_byte : in_req_i.value),
    .re_i    (xor_act && go && vld_q[0]),
    .raddr_i (idx1_q),
    .rdata_o (bb_rd)
  );

  // Evolving permutation, two banks swapped after each conjugation
  assign ev_re    = (xor_act && issue) || (conj_act && vld_q[0]);
  assign ev_raddr = xor_act ? cnt_q[ADDR_W-1:0] : pos_of(finv_rd);
  assign ev_rd    = ev_rd_bank[sel_q];

  for (genvar g = 0; g < 2; g++) begin : g_evo
    pxk_ram #(.WIDTH(ADDR_W), .DEPTH(LENGTH)) u_evo (
      .clk_i   (clk_i),
      .we_i    ((ld_evo && (sel_q == 1'(g))) || (conj_we && (sel_q != 1'(g)))),
      .waddr_i (conj_we ? idx3_q : ld_addr),
      .wdata_i (conj_we ? f_rd : ld_val),
      .re_i    (ev_re),
      .raddr_i (ev_raddr),
      .rdata_o (ev_rd_bank[g])
    );
  end

  // Fixed permutation and its inverse
  assign finv_re = conj_act && issue;

  pxk_ram #(.WIDTH(ADDR_W), .DEPTH(LENGTH)) u_fixed (
    .clk_i   (clk_i),
    .we_i    (ld_fix),
    .waddr_i (ld_addr),
    .wdata_i (ld_val),
    .re_i    (conj_act && vld_q[1]),
    .raddr_i (pos_of(ev_rd)),
    .rdata_o (f_rd)
  );

  pxk_ram #(.WIDTH(ADDR_W), .DEPTH(LENGTH)) u_fixed_inv (
    .clk_i   (clk_i),
    .we_i    (ld_fix),
    .waddr_i (ld_val),
    .wdata_i (ld_addr),
    .re_i    (finv_re),
    .raddr_i (cnt_q[ADDR_W-1:0]),
    .rdata_o (finv_rd)
  );

  // Checks
  a_no_stage3_in_xor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xor_act |-> !vld_q[2])
    else $error("third stage active during XOR pass");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LENGTH))
    else $error("entry counter beyond array length");

  a_out_from_xor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_XOR)
    else $error("output produced outside XOR pass");

  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conj_done |=> sel_q != $past(sel_q))
    else $error("evolving bank not swapped after conjugation");

  a_xor_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_we |-> !ld_key)
    else $error("load collides with XOR write-back");

endmodule

`default_nettype wire

[sv/pxk_ram.sv]
// Generic single-write, single-read RAM with registered read data (read-old on collision).
`default_nettype none

module pxk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
